[rtl/core/gclru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gclru_pkg
// types and status codes shared by the glyph cache lookup modules
// ----------------------------------------------------------------------------
package gclru_pkg;

   localparam int unsigned CHAR_W   = 21;
   localparam int unsigned COLOUR_W = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SLOT_W   = 6;

   localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FILL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EVICT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd3;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_code;
      logic [COLOUR_W-1:0] fore_colour;
      logic [COLOUR_W-1:0] back_colour;
      logic                render_ok;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

endpackage : gclru_pkg
`default_nettype wire

[rtl/core/glyph_cache_lru_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_cache_lru_lookup
// fully associative glyph cell tag store with true lru replacement
// ----------------------------------------------------------------------------
// the key scan reads the slots one by one through the registered memory
// port, then the age pass does a read and, where needed, a write per slot;
// a failed render skips the age pass. The engine takes a new beat only
// once it is done with the last one; the back waits before classifying
// while an earlier result beat is unaccepted; reset: synchronous, valid
// bits clear
module glyph_cache_lru_lookup
   import gclru_pkg::*;
#(
   parameter int unsigned ENTRIES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // queued beats waiting for the back end
   logic    q_valid, q_ready;
   req_type q_data;

   gclru_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // scan, classify and age update
   gclru_engine #(.ENTRIES(ENTRIES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // failure beat always reports slot zero
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FAIL |-> rsp_data.slot == '0)
      else $error("failed render with nonzero slot");

   // result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

endmodule : glyph_cache_lru_lookup
`default_nettype wire

[rtl/core/gclru_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gclru_queue
// two-entry request queue between the front and the back
// ----------------------------------------------------------------------------
module gclru_queue
   import gclru_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output req_type      out_data
);

   req_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule : gclru_queue
`default_nettype wire

[rtl/core/gclru_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gclru_engine
// sequential key scan and age update pass over the tag store
// ----------------------------------------------------------------------------
module gclru_engine
   import gclru_pkg::*;
#(
   parameter int unsigned ENTRIES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam int unsigned KEY_W = CHAR_W + 2 * COLOUR_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_AGE_RD, S_AGE_WR, S_DONE
   } state_type;

   // key and age memories, registered reads
   logic [KEY_W-1:0] key_mem [ENTRIES];
   logic [IDX_W-1:0] age_mem [ENTRIES];
   logic [KEY_W-1:0] key_rd_ff;
   logic [IDX_W-1:0] age_rd_ff;
   logic [ENTRIES-1:0] valid_ff;

   state_type        state_ff;
   req_type          req_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] target_ff;
   logic [IDX_W-1:0] limit_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [IDX_W-1:0] old_age_ff;
   logic [IDX_W-1:0] old_idx_ff;
   logic [CNT_W-1:0] count_ff;
   rsp_type          rsp_ff;
   logic             out_valid_ff;

   logic [KEY_W-1:0] req_key;
   logic             key_we, age_we;
   logic [IDX_W-1:0] age_wr_addr, age_wr_data;

   assign req_key   = {req_ff.char_code, req_ff.fore_colour, req_ff.back_colour};
   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = rsp_ff;

   // age update write: in S_AGE_WR entry idx_ff, or the target in S_DONE
   always_comb begin
      age_we      = 1'b0;
      age_wr_addr = idx_ff;
      age_wr_data = age_rd_ff + IDX_W'(1);
      key_we      = 1'b0;
      if (state_ff == S_AGE_WR) begin
         age_we = valid_ff[idx_ff] && (idx_ff != target_ff)
                  && (hit_ff ? (age_rd_ff < limit_ff) : 1'b1);
      end else if (state_ff == S_DONE && !out_valid_ff) begin
         age_we      = 1'b1;
         age_wr_addr = target_ff;
         age_wr_data = '0;
         key_we      = !hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[idx_ff];
      age_rd_ff <= age_mem[idx_ff];
      if (key_we) key_mem[target_ff] <= req_key;
      if (age_we) age_mem[age_wr_addr] <= age_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  req_ff      <= in_data;
                  idx_ff      <= '0;
                  hit_ff      <= 1'b0;
                  free_ff     <= 1'b0;
                  old_age_ff  <= '0;
                  old_idx_ff  <= '0;
                  state_ff    <= S_SCAN_RD;
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CMP;
            S_SCAN_CMP: begin
               if (valid_ff[idx_ff]) begin
                  if (key_rd_ff == req_key && !hit_ff) begin
                     hit_ff    <= 1'b1;
                     target_ff <= idx_ff;
                     limit_ff  <= age_rd_ff;
                  end
                  if (age_rd_ff > old_age_ff) begin
                     old_age_ff <= age_rd_ff;
                     old_idx_ff <= idx_ff;
                  end
               end else if (!free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= idx_ff;
               end
               if (idx_ff == LAST) begin
                  state_ff <= S_DECIDE;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_DECIDE: begin
               // wait while the result register still holds an earlier beat
               if (!out_valid_ff) begin
                  idx_ff <= '0;
                  if (hit_ff) begin
                     rsp_ff.status <= ST_HIT;
                     state_ff      <= S_AGE_RD;
                  end else if (!req_ff.render_ok) begin
                     rsp_ff.status <= ST_FAIL;
                     rsp_ff.slot   <= '0;
                     out_valid_ff  <= 1'b1;
                     state_ff      <= S_IDLE;
                  end else if (free_ff) begin
                     rsp_ff.status <= ST_FILL;
                     target_ff     <= free_idx_ff;
                     state_ff      <= S_AGE_RD;
                  end else begin
                     rsp_ff.status <= ST_EVICT;
                     target_ff     <= old_idx_ff;
                     state_ff      <= S_AGE_RD;
                  end
               end
            end
            S_AGE_RD: state_ff <= S_AGE_WR;
            S_AGE_WR: begin
               if (idx_ff == LAST) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= S_AGE_RD;
               end
            end
            S_DONE: begin
               if (!out_valid_ff) begin
                  rsp_ff.slot  <= SLOT_W'(target_ff);
                  out_valid_ff <= 1'b1;
                  if (!hit_ff) begin
                     if (!valid_ff[target_ff]) count_ff <= count_ff + CNT_W'(1);
                     valid_ff[target_ff] <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule : gclru_engine
`default_nettype wire
